>>> src/channel_circuit_breaker_unit_assert.svh
// Assertion macros used by the circuit breaker controller.
`ifndef CHANNEL_CIRCUIT_BREAKER_UNIT_ASSERT_SVH
`define CHANNEL_CIRCUIT_BREAKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CCB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ccb_pkg.sv
// Types and constants of the channel circuit breaker.
`timescale 1ns / 1ps
`default_nettype none
package ccb_pkg;

  localparam int CH_W     = 3;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 32;
  localparam int CONSEC_W = 8;
  localparam int THR_W    = 8;
  localparam int SHIFT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_OK   = 2'd0,
    CMD_FAIL = 2'd1,
    CMD_GATE = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COOLDOWN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHIFT      = 2'd2;

  // Configuration reset values
  localparam logic [THR_W-1:0]   RST_FAIL_THRESHOLD = 8'd5;
  localparam logic [TIME_W-1:0]  RST_BASE_COOLDOWN  = 32'd1800000;
  localparam logic [SHIFT_W-1:0] RST_MAX_SHIFT      = 3'd3;

  localparam logic [CONSEC_W-1:0] CONSEC_MAX = '1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // take the input transfer into the work registers
    logic load;     // read the table entry and prepare the update
    logic exec;     // write back the entry and fill the result register
  } ctrl_cmd_t;

endpackage
`default_nettype wire

>>> src/ccb_if.sv
// Channel interfaces: event input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface ccb_in_if
  import ccb_pkg::*;
;
  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [CH_W-1:0]   channel;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, cmd, channel, now_ms, input ready);
  modport sink   (input valid, cmd, channel, now_ms, output ready);
endinterface

interface ccb_out_if
  import ccb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                cooling;
  logic [CNT_W-1:0]    ok_count;
  logic [CNT_W-1:0]    fail_count;
  logic [CNT_W-1:0]    blocked_count;
  logic [CONSEC_W-1:0] consec_fail;
  logic [TIME_W-1:0]   cooldown_end;

  modport source (output valid, cooling, ok_count, fail_count, blocked_count,
                  consec_fail, cooldown_end, input ready);
  modport sink   (input valid, cooling, ok_count, fail_count, blocked_count,
                  consec_fail, cooldown_end, output ready);
endinterface

interface ccb_cfg_if
  import ccb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/channel_circuit_breaker_unit.sv
// An input transfer is captured, then loaded, then executed into the result register.
// The table entry is read in the load cycle and written back in the execute cycle;
// a new event may be captured in the same cycle as the previous one executes.
// A stalled result holds the execute step, and no new event is taken meanwhile.
// Reset (rst_n low, synchronous) clears all channel tables and restores the
// configuration defaults; configuration writes are taken whenever out of reset.
`timescale 1ns / 1ps
`default_nettype none
module channel_circuit_breaker_unit
  import ccb_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ccb_in_if.sink     in_bus,
  ccb_out_if.source  out_bus,
  ccb_cfg_if.sink    cfg_bus
);

  ctrl_cmd_t ctrl_cmd;

  // Take configuration on every cycle out of reset
  assign cfg_bus.ready = rst_n;

  ccb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (ctrl_cmd)
  );

  ccb_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctrl_cmd),
    .cfg_we            (cfg_bus.valid),
    .cfg_index         (cfg_bus.index),
    .cfg_data          (cfg_bus.data),
    .in_cmd            (in_bus.cmd),
    .in_channel        (in_bus.channel),
    .in_now_ms         (in_bus.now_ms),
    .out_cooling       (out_bus.cooling),
    .out_ok_count      (out_bus.ok_count),
    .out_fail_count    (out_bus.fail_count),
    .out_blocked_count (out_bus.blocked_count),
    .out_consec_fail   (out_bus.consec_fail),
    .out_cooldown_end  (out_bus.cooldown_end)
  );

endmodule
`default_nettype wire

>>> src/ccb_ctrl.sv
// Controller: sequences capture, load and execute, and owns the result valid.
`timescale 1ns / 1ps
`default_nettype none
`include "channel_circuit_breaker_unit_assert.svh"
module ccb_ctrl
  import ccb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   exec_fire;
  logic   capture;

  // Execute completes once the result register is free or being drained;
  // hold off input transfers while in reset
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign in_ready  = rst_n && ((state_r == S_IDLE) || exec_fire);
  assign capture   = in_valid && in_ready;

  assign cmd.capture = capture;
  assign cmd.load    = (state_r == S_LOAD);
  assign cmd.exec    = exec_fire;
  assign out_valid   = out_valid_r;

  // Next state and result valid
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (capture) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_nxt = capture ? S_LOAD : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CCB_ASSERT_IMP(a_capture_when_free, clk, rst_n, capture, (state_r == S_IDLE) || (state_r == S_EXEC), "input taken while busy")
  `CCB_ASSERT_NXT(a_load_then_exec, clk, rst_n, state_r == S_LOAD, state_r == S_EXEC, "load not followed by execute")
  `CCB_ASSERT_NXT(a_exec_gives_result, clk, rst_n, exec_fire, out_valid_r, "execute did not present a result")
  `CCB_ASSERT_NXT(a_stall_holds_exec, clk, rst_n, (state_r == S_EXEC) && out_valid_r && !out_ready, state_r == S_EXEC, "execute left while result stalled")

endmodule
`default_nettype wire

>>> src/ccb_dp.sv
// Datapath: configuration registers, per-channel tables and result register.
`timescale 1ns / 1ps
`default_nettype none
module ccb_dp
  import ccb_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  // configuration write
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // event payload
  input  wire cmd_t                  in_cmd,
  input  wire logic [CH_W-1:0]       in_channel,
  input  wire logic [TIME_W-1:0]     in_now_ms,
  // result payload
  output logic                       out_cooling,
  output logic [CNT_W-1:0]           out_ok_count,
  output logic [CNT_W-1:0]           out_fail_count,
  output logic [CNT_W-1:0]           out_blocked_count,
  output logic [CONSEC_W-1:0]        out_consec_fail,
  output logic [TIME_W-1:0]          out_cooldown_end
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers
  logic [THR_W-1:0]   fail_thr_r;
  logic [TIME_W-1:0]  base_cd_r;
  logic [SHIFT_W-1:0] max_shift_r;

  // Channel tables
  logic [CNT_W-1:0]    ok_tab_r     [NUM_CHANNELS];
  logic [CNT_W-1:0]    fail_tab_r   [NUM_CHANNELS];
  logic [CNT_W-1:0]    blk_tab_r    [NUM_CHANNELS];
  logic [CONSEC_W-1:0] consec_tab_r [NUM_CHANNELS];
  logic [TIME_W-1:0]   cd_tab_r     [NUM_CHANNELS];

  // Captured event
  cmd_t              q_cmd_r;
  logic [CH_W-1:0]   q_chan_r;
  logic [TIME_W-1:0] q_now_r;

  // Loaded entry and prepared update
  cmd_t                l_cmd_r;
  logic                l_valid_r;
  logic [IDX_W-1:0]    l_idx_r;
  logic [TIME_W-1:0]   l_now_r;
  logic [CNT_W-1:0]    l_ok_r;
  logic [CNT_W-1:0]    l_fail_r;
  logic [CNT_W-1:0]    l_blk_r;
  logic [CONSEC_W-1:0] l_consec_r;
  logic [TIME_W-1:0]   l_cd_r;
  logic                l_set_r;
  logic [TIME_W-1:0]   l_sh_base_r;
  logic                l_cool_old_r;

  // Load stage signals
  logic                in_range;
  logic [IDX_W-1:0]    rd_idx;
  logic [CONSEC_W-1:0] rd_consec;
  logic [TIME_W-1:0]   rd_cd;
  logic [CONSEC_W-1:0] consec_inc;
  logic [CONSEC_W-1:0] consec_new;
  logic [CONSEC_W-1:0] shift_diff;
  logic [SHIFT_W-1:0]  shift_amt;
  logic                set_cd;

  // Execute stage signals
  logic [TIME_W-1:0] cd_new;
  logic [CNT_W-1:0]  ok_new;
  logic [CNT_W-1:0]  fail_new;
  logic [CNT_W-1:0]  blk_new;
  logic              cool_new;
  logic              wr_en;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_thr_r  <= RST_FAIL_THRESHOLD;
      base_cd_r   <= RST_BASE_COOLDOWN;
      max_shift_r <= RST_MAX_SHIFT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAIL_THRESHOLD: fail_thr_r  <= cfg_data[THR_W-1:0];
        CFG_BASE_COOLDOWN:  base_cd_r   <= cfg_data[TIME_W-1:0];
        CFG_MAX_SHIFT:      max_shift_r <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the event
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_cmd_r  <= in_cmd;
      q_chan_r <= in_channel;
      q_now_r  <= in_now_ms;
    end
  end

  // Load: read the entry, advance the run and pick the backoff shift
  assign in_range  = {1'b0, q_chan_r} < (CH_W + 1)'(NUM_CHANNELS);
  assign rd_idx    = in_range ? q_chan_r[IDX_W-1:0] : '0;
  assign rd_consec = consec_tab_r[rd_idx];
  assign rd_cd     = cd_tab_r[rd_idx];

  always_comb begin
    consec_inc = (rd_consec == CONSEC_MAX) ? CONSEC_MAX : rd_consec + 1'b1;
    case (q_cmd_r)
      CMD_OK:   consec_new = '0;
      CMD_FAIL: consec_new = consec_inc;
      default:  consec_new = rd_consec;
    endcase
    shift_diff = consec_inc - fail_thr_r;
    if (shift_diff > {{(CONSEC_W - SHIFT_W){1'b0}}, max_shift_r}) begin
      shift_amt = max_shift_r;
    end else begin
      shift_amt = shift_diff[SHIFT_W-1:0];
    end
    set_cd = (q_cmd_r == CMD_FAIL) && (consec_inc >= fail_thr_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_cmd_r      <= q_cmd_r;
      l_valid_r    <= in_range;
      l_idx_r      <= rd_idx;
      l_now_r      <= q_now_r;
      l_ok_r       <= ok_tab_r[rd_idx];
      l_fail_r     <= fail_tab_r[rd_idx];
      l_blk_r      <= blk_tab_r[rd_idx];
      l_consec_r   <= consec_new;
      l_cd_r       <= rd_cd;
      l_set_r      <= set_cd;
      // at the threshold itself the difference is zero, so no doubling
      l_sh_base_r  <= base_cd_r << shift_amt;
      l_cool_old_r <= (rd_cd != '0) && (q_now_r < rd_cd);
    end
  end

  // Execute: new counters and cooldown end
  always_comb begin
    if (l_cmd_r == CMD_OK) begin
      cd_new = '0;
    end else if (l_set_r) begin
      cd_new = l_now_r + l_sh_base_r;
    end else begin
      cd_new = l_cd_r;
    end
    ok_new   = (l_cmd_r == CMD_OK)   ? l_ok_r + 1'b1   : l_ok_r;
    fail_new = (l_cmd_r == CMD_FAIL) ? l_fail_r + 1'b1 : l_fail_r;
    blk_new  = ((l_cmd_r == CMD_GATE) && l_cool_old_r) ? l_blk_r + 1'b1 : l_blk_r;
    cool_new = (cd_new != '0) && (l_now_r < cd_new);
    wr_en    = cmd.exec && l_valid_r;
  end

  // Write back the entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ok_tab_r[i]     <= '0;
        fail_tab_r[i]   <= '0;
        blk_tab_r[i]    <= '0;
        consec_tab_r[i] <= '0;
        cd_tab_r[i]     <= '0;
      end
    end else if (wr_en) begin
      ok_tab_r[l_idx_r]     <= ok_new;
      fail_tab_r[l_idx_r]   <= fail_new;
      blk_tab_r[l_idx_r]    <= blk_new;
      consec_tab_r[l_idx_r] <= l_consec_r;
      cd_tab_r[l_idx_r]     <= cd_new;
    end
  end

  // Result register; an absent channel reports all zero
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (l_valid_r) begin
        out_cooling       <= cool_new;
        out_ok_count      <= ok_new;
        out_fail_count    <= fail_new;
        out_blocked_count <= blk_new;
        out_consec_fail   <= l_consec_r;
        out_cooldown_end  <= cd_new;
      end else begin
        out_cooling       <= 1'b0;
        out_ok_count      <= '0;
        out_fail_count    <= '0;
        out_blocked_count <= '0;
        out_consec_fail   <= '0;
        out_cooldown_end  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for the channel circuit breaker: directed and random event streams.
`timescale 1ns / 1ps
module tb;
  import ccb_pkg::*;

  localparam int NUM_CH = 8;

  // One result transfer as the breaker reports it
  typedef struct packed {
    logic                cooling;
    logic [CNT_W-1:0]    ok_count;
    logic [CNT_W-1:0]    fail_count;
    logic [CNT_W-1:0]    blocked_count;
    logic [CONSEC_W-1:0] consec_fail;
    logic [TIME_W-1:0]   cooldown_end;
  } breaker_view_t;

  logic clk;
  logic rst_n;

  ccb_in_if  event_bus ();
  ccb_out_if result_bus ();
  ccb_cfg_if cfg_bus ();

  channel_circuit_breaker_unit #(
    .NUM_CHANNELS(NUM_CH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (event_bus),
    .out_bus(result_bus),
    .cfg_bus(cfg_bus)
  );

  // Predicted channel state, zero as after reset
  logic [CNT_W-1:0]    ok_total      [NUM_CH] = '{default: '0};
  logic [CNT_W-1:0]    fail_total    [NUM_CH] = '{default: '0};
  logic [CNT_W-1:0]    blocked_total [NUM_CH] = '{default: '0};
  logic [CONSEC_W-1:0] fail_run      [NUM_CH] = '{default: '0};
  logic [TIME_W-1:0]   cool_until    [NUM_CH] = '{default: '0};

  // Predicted settings, at their reset values
  logic [THR_W-1:0]   trip_level = RST_FAIL_THRESHOLD;
  logic [TIME_W-1:0]  base_ms    = RST_BASE_COOLDOWN;
  logic [SHIFT_W-1:0] shift_cap  = RST_MAX_SHIFT;

  breaker_view_t pending_views [$];
  int            mismatches = 0;
  bit            idle_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic cooling_at(logic [CH_W-1:0] ch, logic [TIME_W-1:0] t);
    return (cool_until[ch] != '0) && (t < cool_until[ch]);
  endfunction

  // Update the predicted entry for one event and return the view after it
  function automatic breaker_view_t apply_event(cmd_t op, logic [CH_W-1:0] ch,
                                                logic [TIME_W-1:0] t);
    breaker_view_t       view;
    logic [CONSEC_W-1:0] run;
    logic [TIME_W-1:0]   span;
    int unsigned         sh;
    view = '0;
    // an index past the table changes nothing and reads as all zero
    if (int'(ch) >= NUM_CH) return view;
    case (op)
      CMD_OK: begin
        ok_total[ch]   += 1;
        fail_run[ch]   = '0;
        cool_until[ch] = '0;
      end
      CMD_FAIL: begin
        fail_total[ch] += 1;
        if (fail_run[ch] != CONSEC_MAX) fail_run[ch] += 1;
        run = fail_run[ch];
        if (run == trip_level) begin
          cool_until[ch] = t + base_ms;
        end else if (run > trip_level) begin
          // double once per failure past the trip point, capped
          sh = run - trip_level;
          if (sh > shift_cap) sh = shift_cap;
          span = base_ms << sh;
          cool_until[ch] = t + span;
        end
      end
      CMD_GATE: begin
        if (cooling_at(ch, t)) blocked_total[ch] += 1;
      end
      default: ;
    endcase
    view.cooling       = cooling_at(ch, t);
    view.ok_count      = ok_total[ch];
    view.fail_count    = fail_total[ch];
    view.blocked_count = blocked_total[ch];
    view.consec_fail   = fail_run[ch];
    view.cooldown_end  = cool_until[ch];
    return view;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Observe every transfer: settings, events and results
  always @(posedge clk) begin : observe
    breaker_view_t want;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_FAIL_THRESHOLD: trip_level = cfg_bus.data[THR_W-1:0];
          CFG_BASE_COOLDOWN:  base_ms    = cfg_bus.data[TIME_W-1:0];
          CFG_MAX_SHIFT:      shift_cap  = cfg_bus.data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      // check before queueing, so a stray result cannot match a fresh event
      if (result_bus.valid && result_bus.ready) begin
        if (pending_views.size() == 0) begin
          $error("result transfer with no event outstanding");
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          check_field("cooling", want.cooling, result_bus.cooling);
          check_field("ok_count", want.ok_count, result_bus.ok_count);
          check_field("fail_count", want.fail_count, result_bus.fail_count);
          check_field("blocked_count", want.blocked_count, result_bus.blocked_count);
          check_field("consec_fail", want.consec_fail, result_bus.consec_fail);
          check_field("cooldown_end", want.cooldown_end, result_bus.cooldown_end);
        end
      end
      if (event_bus.valid && event_bus.ready)
        pending_views.push_back(apply_event(event_bus.cmd, event_bus.channel,
                                            event_bus.now_ms));
    end
  end

  // Result side: stall in short bursts while idling is on
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
    end
  end

  // Offer one event and hold it until the transfer, then maybe idle
  task automatic send_event(cmd_t op, logic [CH_W-1:0] ch, logic [TIME_W-1:0] t);
    event_bus.valid   <= 1'b1;
    event_bus.cmd     <= op;
    event_bus.channel <= ch;
    event_bus.now_ms  <= t;
    do @(posedge clk); while (!event_bus.ready);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      event_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    event_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_views.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Change settings only once the breaker has gone idle
  task automatic load_settings(logic [THR_W-1:0] thr, logic [TIME_W-1:0] base,
                               logic [SHIFT_W-1:0] sh);
    drain_results();
    write_reg(CFG_FAIL_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_BASE_COOLDOWN, CFG_DATA_W'(base));
    write_reg(CFG_MAX_SHIFT, CFG_DATA_W'(sh));
    cfg_bus.valid <= 1'b0;
  endtask

  // Trip at the reset threshold, double once, let it lapse, then clear
  task automatic test_trip_and_clear();
    repeat (4) send_event(CMD_FAIL, 3'd0, 32'd1000);
    send_event(CMD_FAIL, 3'd0, 32'd1000);
    send_event(CMD_GATE, 3'd0, 32'd2000);
    send_event(CMD_FAIL, 3'd0, 32'd3000);
    send_event(CMD_GATE, 3'd0, 32'd3000 + 2 * RST_BASE_COOLDOWN);
    send_event(CMD_READ, 3'd0, 32'd0);
    send_event(CMD_OK, 3'd0, 32'd5000);
    send_event(CMD_GATE, 3'd0, 32'd5000);
  endtask

  // Extreme settings, zero threshold, wrapping sums and a sum of zero
  task automatic test_config_extremes();
    load_settings(8'd255, 32'd0, 3'd0);
    send_event(CMD_FAIL, 3'd1, 32'hFFFF_FFFF);
    send_event(CMD_READ, 3'd1, 32'd0);
    load_settings(8'd0, 32'hFFFF_FFFF, 3'd7);
    send_event(CMD_FAIL, 3'd7, 32'd0);
    send_event(CMD_GATE, 3'd7, 32'hFFFF_FFFD);
    send_event(CMD_FAIL, 3'd2, 32'd1);
    load_settings(8'd1, 32'd16, 3'd3);
    send_event(CMD_FAIL, 3'd3, 32'hFFFF_FFF0);
    send_event(CMD_GATE, 3'd3, 32'd0);
    send_event(CMD_FAIL, 3'd3, 32'd16);
    send_event(CMD_GATE, 3'd3, 32'd20);
  endtask

  // Drive one run of failures past saturation with the shift at its cap
  task automatic test_saturation();
    logic [TIME_W-1:0] t;
    load_settings(8'd3, 32'd1000, 3'd7);
    t = $urandom;
    for (int i = 0; i < 262; i++) begin
      t += $urandom_range(0, 50);
      send_event(CMD_FAIL, 3'd5, t);
      if (i % 20 == 19) send_event(CMD_GATE, 3'd5, t + $urandom_range(0, 200000));
    end
    send_event(CMD_OK, 3'd5, t);
    send_event(CMD_READ, 3'd5, t);
  endtask

  // Random settings, then a stream focused on one busy channel with a rising clock
  task automatic test_random_phase(int n_items, bit allow_idle);
    logic [THR_W-1:0]   thr;
    logic [TIME_W-1:0]  base;
    logic [SHIFT_W-1:0] sh;
    logic [TIME_W-1:0]  clock_ms;
    logic [CH_W-1:0]    hot;
    logic [CH_W-1:0]    ch;
    cmd_t               op;
    int                 roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) thr = '0;
    else if (roll == 1) thr = '1;
    else thr = $urandom_range(1, 6);
    if ($urandom_range(0, 3) == 0) base = $urandom;
    else base = $urandom_range(1, 2000);
    sh = $urandom_range(0, 7);
    load_settings(thr, base, sh);
    hot      = $urandom_range(0, NUM_CH - 1);
    clock_ms = $urandom;
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) ch = hot;
      else ch = $urandom_range(0, NUM_CH - 1);
      roll = $urandom_range(0, 99);
      if (roll < 45) op = CMD_FAIL;
      else if (roll < 75) op = CMD_GATE;
      else if (roll < 88) op = CMD_OK;
      else op = CMD_READ;
      // mostly a steadily advancing clock, now and then an arbitrary time
      if ($urandom_range(0, 9) == 0) begin
        send_event(op, ch, $urandom);
      end else begin
        clock_ms += $urandom_range(0, 400);
        send_event(op, ch, clock_ms);
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    event_bus.valid   = 1'b0;
    event_bus.cmd     = CMD_OK;
    event_bus.channel = '0;
    event_bus.now_ms  = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_FAIL_THRESHOLD;
    cfg_bus.data      = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_trip_and_clear();
    test_config_extremes();
    test_saturation();
    repeat (3) test_random_phase(190, 1'b1);
    test_random_phase(190, 1'b0);

    // settle, then give the pipeline its latency to show any stray result
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
